/* sv/ptnp_pkg.sv */
// Shared types and constants for the prime test and next-prime unit.
package ptnp_pkg;

   // Width of the input and output value fields.
   localparam int VALUE_WIDTH = 32;

   // Default working width of the arithmetic.
   localparam int WIDTH_DEFAULT = 32;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_CHECK   = 5'b00010,
      S_DIV     = 5'b00100,
      S_RESOLVE = 5'b01000,
      S_FINISH  = 5'b10000
   } state_type;

   // Status from the sequencer to the channel logic.
   typedef struct packed {
      logic idle;
      logic res_valid;
      logic prime_flag;
      logic ovf;
   } res_status_type;

endpackage

/* sv/ptnp_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all trial divisions.
module ptnp_div
   import ptnp_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CW = $clog2(WIDTH + 1);
   localparam logic [CW-1:0] LAST_STEP = CW'(WIDTH - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH+1:0] diff;

   // Shift in the next dividend bit and try the subtraction
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      priority if (start) begin
         // load a new division
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         // advance one quotient bit
         if (!diff[WIDTH+1]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   // Done pulses for one cycle and never while a division runs
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held more than one cycle");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted mid-division");

endmodule

/* sv/ptnp_ctrl.sv */
// Sequencer: trial-division test of the input, then odd-candidate search.
module ptnp_ctrl
   import ptnp_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] start_value,
   input  logic             res_ready,
   output res_status_type   status,
   output logic [WIDTH-1:0] res_found,
   output logic             div_start,
   output logic [WIDTH-1:0] div_dividend,
   output logic [WIDTH-1:0] div_divisor,
   input  logic             div_done,
   input  logic [WIDTH-1:0] div_quo,
   input  logic [WIDTH-1:0] div_rem
);

   localparam logic [WIDTH-1:0] ONE   = WIDTH'(1);
   localparam logic [WIDTH-1:0] TWO   = WIDTH'(2);
   localparam logic [WIDTH-1:0] THREE = WIDTH'(3);

   state_type        state_ff, state_in;
   logic             phase_ff, phase_in;   // 0: testing input, 1: searching
   logic [WIDTH-1:0] value_ff, value_in;
   logic [WIDTH-1:0] cand_ff, cand_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic             tres_ff, tres_in;
   logic             prime_ff, prime_in;
   logic [WIDTH-1:0] found_ff, found_in;
   logic             ovf_ff, ovf_in;
   logic             start_div;
   logic             res_valid;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      value_in  = value_ff;
      cand_in   = cand_ff;
      dsr_in    = dsr_ff;
      tres_in   = tres_ff;
      prime_in  = prime_ff;
      found_in  = found_ff;
      ovf_in    = ovf_ff;
      start_div = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // take a new value
            if (start) begin
               value_in = start_value;
               cand_in  = start_value;
               phase_in = 1'b0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // settle small and even numbers, else start dividing by three
            priority if (cand_ff < TWO) begin
               tres_in  = 1'b0;
               state_in = S_RESOLVE;
            end else if (!cand_ff[0]) begin
               tres_in  = (cand_ff == TWO);
               state_in = S_RESOLVE;
            end else begin
               dsr_in    = THREE;
               start_div = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            // divisor past the square root: prime; zero remainder: composite
            if (div_done) begin
               priority if (dsr_ff > div_quo) begin
                  tres_in  = 1'b1;
                  state_in = S_RESOLVE;
               end else if (div_rem == '0) begin
                  tres_in  = 1'b0;
                  state_in = S_RESOLVE;
               end else begin
                  dsr_in    = dsr_ff + TWO;
                  start_div = 1'b1;
               end
            end
         end
         S_RESOLVE: begin
            state_in = S_CHECK;
            if (!phase_ff) begin
               // input tested: record the flag and set up the search
               prime_in = tres_ff;
               phase_in = 1'b1;
               priority if (value_ff <= TWO) begin
                  found_in = TWO;
                  ovf_in   = 1'b0;
                  state_in = S_FINISH;
               end else if (!value_ff[0]) begin
                  cand_in = value_ff + ONE;
               end else if (tres_ff) begin
                  found_in = value_ff;
                  ovf_in   = 1'b0;
                  state_in = S_FINISH;
               end else if (&value_ff[WIDTH-1:1]) begin
                  found_in = '0;
                  ovf_in   = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  cand_in = value_ff + TWO;
               end
            end else begin
               // candidate tested: stop or step to the next odd one
               priority if (tres_ff) begin
                  found_in = cand_ff;
                  ovf_in   = 1'b0;
                  state_in = S_FINISH;
               end else if (&cand_ff[WIDTH-1:1]) begin
                  found_in = '0;
                  ovf_in   = 1'b1;
                  state_in = S_FINISH;
               end else begin
                  cand_in = cand_ff + TWO;
               end
            end
         end
         S_FINISH: begin
            // hand the result over once the output slot is free
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      phase_ff <= phase_in;
      value_ff <= value_in;
      cand_ff  <= cand_in;
      dsr_ff   <= dsr_in;
      tres_ff  <= tres_in;
      prime_ff <= prime_in;
      found_ff <= found_in;
      ovf_ff   <= ovf_in;
   end

   assign div_start    = start_div;
   assign div_dividend = cand_ff;
   assign div_divisor  = dsr_in;

   assign status    = '{idle: (state_ff == S_IDLE), res_valid: res_valid,
                        prime_flag: prime_ff, ovf: ovf_ff};
   assign res_found = found_ff;

   // Divider runs only on behalf of the trial loop
   a_div_start_state: assert property (@(posedge clock) disable iff (reset)
      start_div |-> (state_ff == S_CHECK || state_ff == S_DIV))
      else $error("division started outside the trial loop");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("division finished with nobody waiting");
   a_odd_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dsr_ff[0] && dsr_ff >= THREE))
      else $error("trial divisor not odd or below three");
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && ovf_ff) |-> (found_ff == '0))
      else $error("overflow result carries a nonzero prime");
   a_res_state: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> state_ff == S_IDLE)
      else $error("sequencer not idle after delivering a result");

endmodule

/* sv/prime_test_and_next_prime_unit.sv */
// Top level of the trial-division prime test and next-prime search unit.
//
// Input channel req_: one beat carries req_candidate_value. Its low WIDTH
// bits are tested for primality and used as the start of an upward search
// for the smallest prime at or above them.
// Result channel rsp_: one beat per input beat, carrying rsp_value_is_prime,
// rsp_next_prime_value (2 for values up to 2) and rsp_search_overflow (set,
// with a zero prime, when no prime at or above the value fits WIDTH bits).
// One item is worked on at a time; req_stall is high while it is in work.
// Each trial divisor takes one pass of the shared restoring divider, so the
// work grows with the trials: up to roughly sqrt(n)/2 odd divisors per tested
// number n, summed over the input and every odd candidate up to the prime.
// Values up to 2 need no division. A 32-bit prime near the top needs tens of
// thousands of trials.
// The result sits in an output register; a new beat is accepted while it
// waits, and rsp_stall holds it there with its payload unchanged.
// Reset clears the sequencer and the output valid; no state is kept
// between items.
module prime_test_and_next_prime_unit
   import ptnp_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_candidate_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_value_is_prime,
   output logic [VALUE_WIDTH-1:0] rsp_next_prime_value,
   output logic                   rsp_search_overflow
);

   res_status_type         status;
   logic [WIDTH-1:0]       start_value;
   logic [WIDTH-1:0]       res_found;
   logic [VALUE_WIDTH-1:0] found_ext;
   logic                   req_accept;
   logic                   slot_free;
   logic                   div_start;
   logic                   div_done;
   logic [WIDTH-1:0]       div_dividend;
   logic [WIDTH-1:0]       div_divisor;
   logic [WIDTH-1:0]       div_quo;
   logic [WIDTH-1:0]       div_rem;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_prime_ff, rsp_prime_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   // Fit the input field to the working width and the result back
   if (WIDTH > VALUE_WIDTH) begin : g_wide
      assign start_value = {{(WIDTH-VALUE_WIDTH){1'b0}}, req_candidate_value};
      assign found_ext   = res_found[VALUE_WIDTH-1:0];
   end else if (WIDTH == VALUE_WIDTH) begin : g_equal
      assign start_value = req_candidate_value;
      assign found_ext   = res_found;
   end else begin : g_narrow
      assign start_value = req_candidate_value[WIDTH-1:0];
      assign found_ext   = {{(VALUE_WIDTH-WIDTH){1'b0}}, res_found};
   end

   assign req_stall  = !status.idle;
   assign req_accept = req_valid && !req_stall;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   ptnp_ctrl #(
      .WIDTH(WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .start_value (start_value),
      .res_ready   (slot_free),
      .status      (status),
      .res_found   (res_found),
      .div_start   (div_start),
      .div_dividend(div_dividend),
      .div_divisor (div_divisor),
      .div_done    (div_done),
      .div_quo     (div_quo),
      .div_rem     (div_rem)
   );

   ptnp_div #(
      .WIDTH(WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   // Load the output register on a new result, drop valid when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_value_in = rsp_value_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      priority if (status.res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = status.prime_flag;
         rsp_value_in = found_ext;
         rsp_ovf_in   = status.ovf;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_prime_ff <= rsp_prime_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_value_is_prime   = rsp_prime_ff;
   assign rsp_next_prime_value = rsp_value_ff;
   assign rsp_search_overflow  = rsp_ovf_ff;

   // A new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      status.res_valid |-> slot_free)
      else $error("result beat overwritten while stalled");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !status.idle)
      else $error("sequencer did not start on an accepted beat");
   a_ovf_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_value_ff == '0))
      else $error("overflow beat with nonzero prime");

endmodule

/* tb/sv/prime_result_checker.sv */
// Checker for the prime test unit: predicts each answer and compares result beats.
module prime_result_checker
   import ptnp_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_candidate_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_value_is_prime,
   input  logic [VALUE_WIDTH-1:0] rsp_next_prime_value,
   input  logic                   rsp_search_overflow,
   output int                     fail_count,
   output int                     pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Working width wide enough for any WIDTH the block supports.
   typedef bit [63:0] wide_type;

   typedef struct {
      logic [VALUE_WIDTH-1:0] candidate;
      logic                   prime_flag;
      logic [VALUE_WIDTH-1:0] next_value;
      logic                   overflow;
   } prime_answer_type;

   prime_answer_type expected_answers[$];
   int               failures = 0;

   // Trial division by 2, then odd divisors while d <= n / d.
   function automatic bit trial_division_prime(wide_type n);
      wide_type d;
      if (n < 2) return 1'b0;
      if (n[0] == 1'b0) return n == 2;
      for (d = 3; d <= n / d; d += 2) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Primality of the reduced value and the smallest prime at or above it.
   function automatic prime_answer_type predict_answer(logic [VALUE_WIDTH-1:0] cand);
      prime_answer_type answer;
      wide_type         limit;
      wide_type         value;
      wide_type         probe;
      bit               found;
      bit               done;
      limit = ((wide_type'(1) << (WIDTH - 1)) << 1) - 1;
      value = wide_type'(cand) & limit;
      answer.candidate  = cand;
      answer.prime_flag = trial_division_prime(value);
      found = 1'b0;
      done  = 1'b0;
      probe = value;
      if (value <= 2) begin
         probe = 2;
         found = 1'b1;
         done  = 1'b1;
      end else if (probe[0] == 1'b0) begin
         // Round up to odd, unless that leaves the width.
         if (probe >= limit) done = 1'b1;
         else probe += 1;
      end
      while (!done) begin
         if (trial_division_prime(probe)) begin
            found = 1'b1;
            done  = 1'b1;
         end else if (limit - probe < 2) begin
            done = 1'b1;
         end else begin
            probe += 2;
         end
      end
      answer.next_value = found ? probe[VALUE_WIDTH-1:0] : '0;
      answer.overflow   = !found;
      return answer;
   endfunction

   task automatic report_mismatch(string field, logic [VALUE_WIDTH-1:0] cand,
                                  logic [63:0] want, logic [63:0] got);
      $display("%0t: %s mismatch for candidate %0d: expected %0d, actual %0d",
               $time, field, cand, want, got);
      failures++;
   endtask

   // Pop the oldest answer for each result beat, queue one for each input beat.
   always @(posedge clock) begin : compare_beats
      prime_answer_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected result beat: prime %b, next %0d, overflow %b",
                        $time, rsp_value_is_prime, rsp_next_prime_value,
                        rsp_search_overflow);
               failures++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_value_is_prime !== want.prime_flag)
                  report_mismatch("value_is_prime", want.candidate,
                                  64'(want.prime_flag), 64'(rsp_value_is_prime));
               if (rsp_next_prime_value !== want.next_value)
                  report_mismatch("next_prime_value", want.candidate,
                                  64'(want.next_value), 64'(rsp_next_prime_value));
               if (rsp_search_overflow !== want.overflow)
                  report_mismatch("search_overflow", want.candidate,
                                  64'(want.overflow), 64'(rsp_search_overflow));
            end
         end
         if (req_valid && !req_stall)
            expected_answers.push_back(predict_answer(req_candidate_value));
      end
      pending_count <= expected_answers.size();
      fail_count    <= failures;
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the prime test unit testbench: clock, reset, stimulus, stalls and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ptnp_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int HOLD_CYCLES    = 3000;
   localparam int SETTLE_CYCLES  = 200;
   localparam int RANDOM_ITEMS   = 52;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [VALUE_WIDTH-1:0] req_candidate_value;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_value_is_prime;
   logic [VALUE_WIDTH-1:0] rsp_next_prime_value;
   logic                   rsp_search_overflow;
   int                     fail_count;
   int                     pending_count;

   // Set by the stimulus: free_flow drops all idling, hold_wanted asks for a long stall.
   bit free_flow   = 1'b0;
   bit hold_wanted = 1'b0;
   int idle_cycles;

   // Boundaries, squares of primes, prime gaps and the top of the range.
   logic [VALUE_WIDTH-1:0] directed_values [20] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd8, 32'd9, 32'd25, 32'd49,
      32'd90, 32'd114, 32'd121, 32'd1021, 32'd1024, 32'd65521, 32'd65535,
      32'd65536, 32'hFFFF_FFFE, 32'hFFFF_FFFF
   };

   prime_test_and_next_prime_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_candidate_value  (req_candidate_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_value_is_prime   (rsp_value_is_prime),
      .rsp_next_prime_value (rsp_next_prime_value),
      .rsp_search_overflow  (rsp_search_overflow)
   );

   prime_result_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_candidate_value  (req_candidate_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_value_is_prime   (rsp_value_is_prime),
      .rsp_next_prime_value (rsp_next_prime_value),
      .rsp_search_overflow  (rsp_search_overflow),
      .fail_count           (fail_count),
      .pending_count        (pending_count)
   );

   always #4 clock = ~clock;

   // Mostly short gaps, a few long ones.
   function automatic int pick_run_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 3);
      else if (pick < 95) return $urandom_range(4, 16);
      else return $urandom_range(40, 200);
   endfunction

   function automatic int pick_gap();
      if (free_flow || $urandom_range(0, 99) < 50) return 0;
      return pick_run_length();
   endfunction

   // Mostly small values keep the trial division short; a few reach 20 bits, a rare few sit at the 32-bit top.
   function automatic logic [VALUE_WIDTH-1:0] random_candidate();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) return $urandom_range(0, 255);
      else if (pick < 75) return $urandom_range(0, 4095);
      else if (pick < 90) return $urandom_range(4096, 65535);
      else if (pick < 97) return $urandom_range(65536, 1048575);
      else return 32'hFFFF_FFFF - $urandom_range(0, 1);
   endfunction

   // Idle for a gap, then hold the beat until accepted; returns at a falling edge.
   task automatic send_candidate(logic [VALUE_WIDTH-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_candidate_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drive the result stall: random runs, a long hold on request, none in free flow.
   initial begin : result_receiver
      int run_left;
      bit run_level;
      run_left  = 0;
      run_level = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            run_left = 0;
         end else if (free_flow) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_level = ($urandom_range(0, 99) < 35);
               run_left  = pick_run_length();
            end
            rsp_stall <= run_level;
            run_left--;
         end
      end
   end

   // End the run when no beat moves on either channel for too long.
   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      clock               = 1'b0;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_candidate_value = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_values[i]) send_candidate(directed_values[i]);

      // Hold off results while tiny values keep coming, so the input backs up.
      hold_wanted = 1'b1;
      repeat (12) send_candidate($urandom_range(0, 100));

      // Run a burst with no idling on either side.
      free_flow = 1'b1;
      repeat (16) send_candidate($urandom_range(0, 2047));
      free_flow = 1'b0;

      repeat (RANDOM_ITEMS) send_candidate(random_candidate());
      req_valid <= 1'b0;

      // Drain, then give stray beats a chance to show up.
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/ptnp_pkg.sv
sv/ptnp_div.sv
sv/ptnp_ctrl.sv
sv/prime_test_and_next_prime_unit.sv
tb/sv/prime_result_checker.sv
tb/sv/testbench.sv
